### hdl/tcgr_pkg.sv
// Shared types and constants for the text console glyph renderer.
// Depends on nothing; all other source files but tcgr_ram refer to it by scoped names.
package tcgr_pkg;

    // Frame geometry and store sizes
    localparam int FB_W        = 128;
    localparam int FB_H        = 64;
    localparam int MAX_ROWS    = 16;
    localparam int CELL_W      = 8;
    localparam int FB_DEPTH    = FB_W * FB_H;
    localparam int GLYPH_DEPTH = 256 * MAX_ROWS;
    localparam int FB_AW       = $clog2(FB_DEPTH);
    localparam int GL_AW       = $clog2(GLYPH_DEPTH);

    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [31:0] FG_RESET     = 32'hFFFF_FFFF;
    localparam logic [31:0] BG_RESET     = 32'h0000_0000;

    // Request codes on the input channel
    localparam logic [2:0] REQ_CHAR  = 3'd0;
    localparam logic [2:0] REQ_BS    = 3'd1;
    localparam logic [2:0] REQ_MOVE  = 3'd2;
    localparam logic [2:0] REQ_CLEAR = 3'd3;
    localparam logic [2:0] REQ_LOAD  = 3'd4;
    localparam logic [2:0] REQ_READ  = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_FG     = 3'd0;
    localparam logic [2:0] CFG_BG     = 3'd1;
    localparam logic [2:0] CFG_ROWS   = 3'd2;
    localparam logic [2:0] CFG_EN     = 3'd3;
    localparam logic [2:0] CFG_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_HEIGHT = 3'd5;

    // Classified operation handed from front to engine
    typedef enum logic [2:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_BS,
        OP_MOVE,
        OP_CLEAR,
        OP_LOAD,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] code;
        logic [6:0] pos_x;
        logic [5:0] pos_y;
        logic [3:0] grow_idx;
        logic [7:0] grow_bits;
    } cmd_t;

    typedef struct packed {
        logic [31:0] fg;
        logic [31:0] bg;
        logic [4:0]  rows;
        logic        en;
        logic [7:0]  width;
        logic [6:0]  height;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_NL,
        ST_GROW,
        ST_GPIX,
        ST_ERASE,
        ST_CLEAR,
        ST_SC_RD,
        ST_SC_WR,
        ST_FILL,
        ST_RDWAIT,
        ST_DONE
    } state_t;

endpackage

### hdl/tcgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

### hdl/tcgr_front.sv
// Front end: takes requests, classifies them and queues them for the engine.
// Depends on tcgr_pkg.
module tcgr_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            hold,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [2:0]      s_req_type,
    input  logic [7:0]      s_char_code,
    input  logic [6:0]      s_pos_x,
    input  logic [5:0]      s_pos_y,
    input  logic [3:0]      s_glyph_row_index,
    input  logic [7:0]      s_glyph_row_bits,
    output logic            cmd_valid,
    output tcgr_pkg::cmd_t  cmd,
    input  logic            cmd_pop
);
    tcgr_pkg::cmd_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    tcgr_pkg::cmd_t in_cmd;
    logic       push;

    // Decode request code into an operation
    always_comb begin
        in_cmd.code      = s_char_code;
        in_cmd.pos_x     = s_pos_x;
        in_cmd.pos_y     = s_pos_y;
        in_cmd.grow_idx  = s_glyph_row_index;
        in_cmd.grow_bits = s_glyph_row_bits;
        case (s_req_type)
            tcgr_pkg::REQ_CHAR: begin
                in_cmd.op = (s_char_code == tcgr_pkg::NEWLINE_CODE) ?
                            tcgr_pkg::OP_NEWLINE : tcgr_pkg::OP_CHAR;
            end
            tcgr_pkg::REQ_BS:    in_cmd.op = tcgr_pkg::OP_BS;
            tcgr_pkg::REQ_MOVE:  in_cmd.op = tcgr_pkg::OP_MOVE;
            tcgr_pkg::REQ_CLEAR: in_cmd.op = tcgr_pkg::OP_CLEAR;
            tcgr_pkg::REQ_LOAD:  in_cmd.op = tcgr_pkg::OP_LOAD;
            tcgr_pkg::REQ_READ:  in_cmd.op = tcgr_pkg::OP_READ;
            default:             in_cmd.op = tcgr_pkg::OP_NOP;
        endcase
    end

    // Two-entry queue
    assign s_ready   = (cnt_reg != 2'd2) && !hold;
    assign push      = s_valid && s_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = cmd_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= in_cmd;
        end
    end
endmodule

### hdl/tcgr_engine.sv
// Back end: sequencer that walks pixels, owns the frame and glyph stores,
// the cursor and the result register. Depends on tcgr_pkg and tcgr_ram.
module tcgr_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  tcgr_pkg::cfg_t  cfg,
    input  logic            cmd_valid,
    input  tcgr_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    output logic            init_busy,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [31:0]     m_pixel_value,
    output logic [6:0]      m_cursor_col,
    output logic [5:0]      m_cursor_row
);
    tcgr_pkg::state_t state_reg, state_next;
    logic [tcgr_pkg::FB_AW-1:0] init_reg, init_next;
    logic [6:0]  cx_reg, cx_next;
    logic [5:0]  cy_reg, cy_next;
    logic [7:0]  x_reg, x_next;
    logic [6:0]  y_reg, y_next;
    logic [2:0]  dx_reg, dx_next;
    logic [4:0]  dy_reg, dy_next;
    logic [7:0]  code_reg, code_next;
    logic [31:0] pix_reg, pix_next;
    logic        inr_reg, inr_next;
    logic        mv_reg, mv_next;
    logic [31:0] mpix_reg, mpix_next;
    logic [6:0]  mcol_reg, mcol_next;
    logic [5:0]  mrow_reg, mrow_next;

    logic                       fb_we, fb_re;
    logic [tcgr_pkg::FB_AW-1:0] fb_waddr, fb_raddr;
    logic [31:0]                fb_wdata, fb_rdata;
    logic                       gl_we, gl_re;
    logic [tcgr_pkg::GL_AW-1:0] gl_waddr, gl_raddr;
    logic [7:0]                 gl_rdata;

    logic [7:0] w_eff, wmax, px, adv;
    logic [6:0] h_eff, hmax, py, cy7, r7, ny, ys;
    logic [4:0] r_eff;
    logic       in_cell;

    tcgr_ram #(.WIDTH(32), .DEPTH(tcgr_pkg::FB_DEPTH)) u_fb (
        .aclk(aclk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
        .re(fb_re), .raddr(fb_raddr), .rdata(fb_rdata)
    );

    tcgr_ram #(.WIDTH(8), .DEPTH(tcgr_pkg::GLYPH_DEPTH)) u_glyph (
        .aclk(aclk), .we(gl_we), .waddr(gl_waddr), .wdata(cmd.grow_bits),
        .re(gl_re), .raddr(gl_raddr), .rdata(gl_rdata)
    );

    // Effective sizes and limits
    always_comb begin
        w_eff = (cfg.width > 8'(tcgr_pkg::FB_W)) ? 8'(tcgr_pkg::FB_W) : cfg.width;
        h_eff = (cfg.height > 7'(tcgr_pkg::FB_H)) ? 7'(tcgr_pkg::FB_H) : cfg.height;
        if (cfg.rows == 5'd0) begin
            r_eff = 5'd1;
        end else if (cfg.rows > 5'(tcgr_pkg::MAX_ROWS)) begin
            r_eff = 5'(tcgr_pkg::MAX_ROWS);
        end else begin
            r_eff = cfg.rows;
        end
        r7   = {2'b0, r_eff};
        cy7  = {1'b0, cy_reg};
        wmax = (w_eff > 8'(tcgr_pkg::CELL_W)) ? w_eff - 8'(tcgr_pkg::CELL_W) : 8'd0;
        hmax = (h_eff > r7) ? h_eff - r7 : 7'd0;
        px   = {1'b0, cx_reg} + {5'b0, dx_reg};
        py   = cy7 + {2'b0, dy_reg};
        in_cell = (px < w_eff) && (py < h_eff);
        adv  = {1'b0, cx_reg} + 8'(tcgr_pkg::CELL_W);
        ny   = cy7 + r7;
        ys   = y_reg - r7;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        init_next  = init_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        code_next  = code_reg;
        pix_next   = pix_reg;
        inr_next   = inr_reg;
        mv_next    = mv_reg && !m_ready;
        mpix_next  = mpix_reg;
        mcol_next  = mcol_reg;
        mrow_next  = mrow_reg;
        cmd_pop    = 1'b0;
        fb_we      = 1'b0;
        fb_waddr   = {py[5:0], px[6:0]};
        fb_wdata   = cfg.fg;
        fb_re      = 1'b0;
        fb_raddr   = {y_reg[5:0], x_reg[6:0]};
        gl_we      = 1'b0;
        gl_waddr   = ({4'b0, cmd.code} * {7'b0, r_eff}) + {8'b0, cmd.grow_idx};
        gl_re      = 1'b0;
        gl_raddr   = ({4'b0, code_reg} * {7'b0, r_eff}) + {7'b0, dy_reg};

        case (state_reg)
            // Zero the frame store after reset
            tcgr_pkg::ST_INIT: begin
                fb_we     = 1'b1;
                fb_waddr  = init_reg;
                fb_wdata  = 32'd0;
                init_next = init_reg + 1'b1;
                if (&init_reg) begin
                    state_next = tcgr_pkg::ST_IDLE;
                end
            end
            // Take the next request
            tcgr_pkg::ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop    = 1'b1;
                    code_next  = cmd.code;
                    pix_next   = 32'd0;
                    x_next     = 8'd0;
                    y_next     = 7'd0;
                    dx_next    = 3'd0;
                    dy_next    = 5'd0;
                    state_next = tcgr_pkg::ST_DONE;
                    case (cmd.op)
                        tcgr_pkg::OP_CHAR: begin
                            if (cfg.en) state_next = tcgr_pkg::ST_GROW;
                        end
                        tcgr_pkg::OP_NEWLINE: begin
                            if (cfg.en) state_next = tcgr_pkg::ST_NL;
                        end
                        tcgr_pkg::OP_BS: begin
                            if (!(cx_reg < 7'd8 && cy7 < r7)) begin
                                if (cx_reg < 7'd8) begin
                                    cx_next = wmax[6:0];
                                    cy_next = cy_reg - {1'b0, r_eff};
                                end else begin
                                    cx_next = cx_reg - 7'd8;
                                end
                                if (cfg.en) state_next = tcgr_pkg::ST_ERASE;
                            end
                        end
                        tcgr_pkg::OP_MOVE: begin
                            cx_next = ({1'b0, cmd.pos_x} <= wmax) ? cmd.pos_x : wmax[6:0];
                            cy_next = ({1'b0, cmd.pos_y} <= hmax) ? cmd.pos_y : hmax[5:0];
                        end
                        tcgr_pkg::OP_CLEAR: begin
                            cx_next = 7'd0;
                            cy_next = 6'd0;
                            if (cfg.en) state_next = tcgr_pkg::ST_CLEAR;
                        end
                        tcgr_pkg::OP_LOAD: begin
                            gl_we = ({1'b0, cmd.grow_idx} < r_eff);
                        end
                        tcgr_pkg::OP_READ: begin
                            fb_raddr   = {cmd.pos_y, cmd.pos_x};
                            inr_next   = ({1'b0, cmd.pos_x} < w_eff) &&
                                         ({1'b0, cmd.pos_y} < h_eff);
                            fb_re      = 1'b1;
                            state_next = tcgr_pkg::ST_RDWAIT;
                        end
                        default: state_next = tcgr_pkg::ST_DONE;
                    endcase
                end
            end
            // New line, scrolling when past the bottom
            tcgr_pkg::ST_NL: begin
                cx_next = 7'd0;
                if (ny < h_eff) begin
                    cy_next    = ny[5:0];
                    state_next = tcgr_pkg::ST_DONE;
                end else begin
                    cy_next    = hmax[5:0];
                    y_next     = r7;
                    x_next     = 8'd0;
                    state_next = tcgr_pkg::ST_SC_RD;
                end
            end
            // Fetch one glyph row, or advance the cursor when done
            tcgr_pkg::ST_GROW: begin
                if (dy_reg >= r_eff) begin
                    if (adv >= w_eff) begin
                        state_next = tcgr_pkg::ST_NL;
                    end else begin
                        cx_next    = adv[6:0];
                        state_next = tcgr_pkg::ST_DONE;
                    end
                end else begin
                    gl_re      = 1'b1;
                    state_next = tcgr_pkg::ST_GPIX;
                end
            end
            // Paint set bits of the row, MSB leftmost
            tcgr_pkg::ST_GPIX: begin
                fb_we   = gl_rdata[3'd7 - dx_reg] && in_cell;
                dx_next = dx_reg + 3'd1;
                if (dx_reg == 3'd7) begin
                    dy_next    = dy_reg + 5'd1;
                    state_next = tcgr_pkg::ST_GROW;
                end
            end
            // Erase cell in background color
            tcgr_pkg::ST_ERASE: begin
                if (dy_reg >= r_eff) begin
                    state_next = tcgr_pkg::ST_DONE;
                end else begin
                    fb_we    = in_cell;
                    fb_wdata = cfg.bg;
                    dx_next  = dx_reg + 3'd1;
                    if (dx_reg == 3'd7) dy_next = dy_reg + 5'd1;
                end
            end
            // Whole-screen fill in background color for clear; zero fill of the bottom text line after a scroll
            tcgr_pkg::ST_CLEAR, tcgr_pkg::ST_FILL: begin
                if (y_reg >= h_eff) begin
                    state_next = tcgr_pkg::ST_DONE;
                end else if (x_reg >= w_eff) begin
                    x_next = 8'd0;
                    y_next = y_reg + 7'd1;
                end else begin
                    fb_we    = 1'b1;
                    fb_waddr = {y_reg[5:0], x_reg[6:0]};
                    fb_wdata = (state_reg == tcgr_pkg::ST_CLEAR) ? cfg.bg : 32'd0;
                    x_next   = x_reg + 8'd1;
                end
            end
            // Scroll: read source pixel
            tcgr_pkg::ST_SC_RD: begin
                if (y_reg >= h_eff) begin
                    y_next     = hmax;
                    x_next     = 8'd0;
                    state_next = tcgr_pkg::ST_FILL;
                end else if (x_reg >= w_eff) begin
                    x_next = 8'd0;
                    y_next = y_reg + 7'd1;
                end else begin
                    fb_re      = 1'b1;
                    state_next = tcgr_pkg::ST_SC_WR;
                end
            end
            // Scroll: write it one text line up
            tcgr_pkg::ST_SC_WR: begin
                fb_we      = 1'b1;
                fb_waddr   = {ys[5:0], x_reg[6:0]};
                fb_wdata   = fb_rdata;
                x_next     = x_reg + 8'd1;
                state_next = tcgr_pkg::ST_SC_RD;
            end
            tcgr_pkg::ST_RDWAIT: begin
                pix_next   = inr_reg ? fb_rdata : 32'd0;
                state_next = tcgr_pkg::ST_DONE;
            end
            // Load result register once it is free
            tcgr_pkg::ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mpix_next  = pix_reg;
                    mcol_next  = cx_reg;
                    mrow_next  = cy_reg;
                    state_next = tcgr_pkg::ST_IDLE;
                end
            end
            default: state_next = tcgr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcgr_pkg::ST_INIT;
            init_reg  <= '0;
            cx_reg    <= 7'd0;
            cy_reg    <= 6'd0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            init_reg  <= init_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        code_reg <= code_next;
        pix_reg  <= pix_next;
        inr_reg  <= inr_next;
        mpix_reg <= mpix_next;
        mcol_reg <= mcol_next;
        mrow_reg <= mrow_next;
    end

    assign init_busy     = (state_reg == tcgr_pkg::ST_INIT);
    assign m_valid       = mv_reg;
    assign m_pixel_value = mpix_reg;
    assign m_cursor_col  = mcol_reg;
    assign m_cursor_row  = mrow_reg;
endmodule

### hdl/text_console_glyph_renderer.sv
// Top level of the text console glyph renderer: config registers, front
// queue and drawing engine. Depends on tcgr_pkg, tcgr_front, tcgr_engine.
//
//  channel | ports           | moves
//  --------+-----------------+-------------------------------------------
//  request | s_valid/s_ready | req_type, char, position, glyph row data
//  result  | m_valid/m_ready | pixel value, cursor column and row
//  config  | cfg_valid/ready | register index and 32-bit data
//
// One request at a time in the engine; front queue holds two more.
// Character: per glyph row one fetch in ST_GROW, then one pixel a cycle.
// Scroll reads (ST_SC_RD), then writes (ST_SC_WR) each copied pixel through
// the single frame store port pair; scroll and clear add a step per row.
// After reset all 8192 frame store words are zeroed; no request is taken.
// A full result register stalls the engine; the front keeps filling.
module text_console_glyph_renderer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [7:0]  s_char_code,
    input  logic [6:0]  s_pos_x,
    input  logic [5:0]  s_pos_y,
    input  logic [3:0]  s_glyph_row_index,
    input  logic [7:0]  s_glyph_row_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_value,
    output logic [6:0]  m_cursor_col,
    output logic [5:0]  m_cursor_row,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    tcgr_pkg::cfg_t cfg_reg;
    tcgr_pkg::cmd_t cmd;
    logic           cmd_valid, cmd_pop, init_busy;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fg     <= tcgr_pkg::FG_RESET;
            cfg_reg.bg     <= tcgr_pkg::BG_RESET;
            cfg_reg.rows   <= 5'(tcgr_pkg::MAX_ROWS);
            cfg_reg.en     <= 1'b1;
            cfg_reg.width  <= 8'(tcgr_pkg::FB_W);
            cfg_reg.height <= 7'(tcgr_pkg::FB_H);
        end else if (cfg_valid) begin
            case (cfg_index)
                tcgr_pkg::CFG_FG:     cfg_reg.fg     <= cfg_data;
                tcgr_pkg::CFG_BG:     cfg_reg.bg     <= cfg_data;
                tcgr_pkg::CFG_ROWS:   cfg_reg.rows   <= cfg_data[4:0];
                tcgr_pkg::CFG_EN:     cfg_reg.en     <= cfg_data[0];
                tcgr_pkg::CFG_WIDTH:  cfg_reg.width  <= cfg_data[7:0];
                tcgr_pkg::CFG_HEIGHT: cfg_reg.height <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    tcgr_front u_front (
        .aclk(aclk), .aresetn(aresetn), .hold(init_busy),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_char_code(s_char_code),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y),
        .s_glyph_row_index(s_glyph_row_index),
        .s_glyph_row_bits(s_glyph_row_bits),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
    );

    tcgr_engine u_engine (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
        .init_busy(init_busy),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pixel_value(m_pixel_value),
        .m_cursor_col(m_cursor_col), .m_cursor_row(m_cursor_row)
    );

    // No result may appear while the frame store is still being zeroed
    a_no_result_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        init_busy |-> !m_valid)
        else $error("result during frame store init");

    // Engine only pops a queued request
    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> cmd_valid && !init_busy)
        else $error("pop from empty request queue");

    // Requests are not taken while zeroing
    a_init_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(init_busy) && init_busy |-> !s_ready)
        else $error("request taken during init");
endmodule

### dv/testbench.sv
// Testbench for text_console_glyph_renderer, uses tcgr_pkg. A console model predicts
// each response; beyond a directed start, requests, stalls and some configs are random.
`timescale 1ns / 100ps

module testbench;

    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;
    localparam int CYCLE_LIMIT = 30_000_000;
    localparam int PHASE_REQS  = 75;

    // Console model plus the queue of predicted responses
    class console_scoreboard;
        logic [31:0] frame [tcgr_pkg::FB_DEPTH];
        logic [7:0]  glyph [tcgr_pkg::GLYPH_DEPTH];
        int cur_x, cur_y;
        logic [31:0] fg, bg;
        int rows, width, height;
        bit en;
        logic [31:0] exp_pixel [$];
        logic [6:0]  exp_col [$];
        logic [5:0]  exp_row [$];
        int errors;

        function new();
            foreach (frame[i]) frame[i] = '0;
            foreach (glyph[i]) glyph[i] = '0;
            cur_x = 0; cur_y = 0;
            fg = tcgr_pkg::FG_RESET; bg = tcgr_pkg::BG_RESET;
            rows = 16; en = 1; width = 128; height = 64;
            errors = 0;
        endfunction

        function int vis_w();
            return width < tcgr_pkg::FB_W ? width : tcgr_pkg::FB_W;
        endfunction

        function int vis_h();
            return height < tcgr_pkg::FB_H ? height : tcgr_pkg::FB_H;
        endfunction

        function int rows_eff();
            if (rows < 1) return 1;
            if (rows > tcgr_pkg::MAX_ROWS) return tcgr_pkg::MAX_ROWS;
            return rows;
        endfunction

        function int sat_sub(int a, int b);
            return a > b ? a - b : 0;
        endfunction

        function void put_px(int x, int y, logic [31:0] c);
            if (!en || x >= vis_w() || y >= vis_h()) return;
            frame[y * tcgr_pkg::FB_W + x] = c;
        endfunction

        function logic [31:0] get_px(int x, int y);
            if (x >= vis_w() || y >= vis_h()) return '0;
            return frame[y * tcgr_pkg::FB_W + x];
        endfunction

        function void new_line();
            int r, h;
            r = rows_eff();
            h = vis_h();
            cur_x = 0;
            cur_y += r;
            if (cur_y >= h) begin
                cur_y = sat_sub(h, r);
                // scroll one text line up, blank the bottom
                for (int y = r; y < h; y++)
                    for (int x = 0; x < vis_w(); x++)
                        put_px(x, y - r, get_px(x, y));
                for (int y = sat_sub(h, r); y < h; y++)
                    for (int x = 0; x < vis_w(); x++)
                        put_px(x, y, '0);
            end
        endfunction

        function void move_to(int x, int y);
            int mx, my;
            mx = sat_sub(vis_w(), tcgr_pkg::CELL_W);
            my = sat_sub(vis_h(), rows_eff());
            cur_x = x <= mx ? x : mx;
            cur_y = y <= my ? y : my;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                tcgr_pkg::CFG_FG:     fg = d;
                tcgr_pkg::CFG_BG:     bg = d;
                tcgr_pkg::CFG_ROWS:   rows = d[4:0];
                tcgr_pkg::CFG_EN:     en = d[0];
                tcgr_pkg::CFG_WIDTH:  width = d[7:0];
                tcgr_pkg::CFG_HEIGHT: height = d[6:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic [2:0] req, logic [7:0] code, logic [6:0] px,
                                   logic [5:0] py, logic [3:0] gi, logic [7:0] gb);
            logic [31:0] pixel;
            int r, addr;
            pixel = '0;
            r = rows_eff();
            case (req)
                tcgr_pkg::REQ_CHAR: if (en) begin
                    if (code == tcgr_pkg::NEWLINE_CODE) new_line();
                    else begin
                        for (int dy = 0; dy < r; dy++) begin
                            addr = code * r + dy;
                            for (int dx = 0; dx < tcgr_pkg::CELL_W; dx++)
                                if (addr < tcgr_pkg::GLYPH_DEPTH && glyph[addr][7 - dx])
                                    put_px(cur_x + dx, cur_y + dy, fg);
                        end
                        cur_x += tcgr_pkg::CELL_W;
                        if (cur_x >= vis_w()) new_line();
                    end
                end
                tcgr_pkg::REQ_BS: if (!(cur_x < tcgr_pkg::CELL_W && cur_y < r)) begin
                    if (cur_x < tcgr_pkg::CELL_W) begin
                        cur_x = sat_sub(vis_w(), tcgr_pkg::CELL_W);
                        cur_y -= r;
                    end else begin
                        cur_x -= tcgr_pkg::CELL_W;
                    end
                    for (int dy = 0; dy < r; dy++)
                        for (int dx = 0; dx < tcgr_pkg::CELL_W; dx++)
                            put_px(cur_x + dx, cur_y + dy, bg);
                end
                tcgr_pkg::REQ_MOVE: move_to(px, py);
                tcgr_pkg::REQ_CLEAR: begin
                    for (int y = 0; y < vis_h(); y++)
                        for (int x = 0; x < vis_w(); x++)
                            put_px(x, y, bg);
                    move_to(0, 0);
                end
                tcgr_pkg::REQ_LOAD: if (gi < r) begin
                    addr = code * r + gi;
                    if (addr < tcgr_pkg::GLYPH_DEPTH) glyph[addr] = gb;
                end
                tcgr_pkg::REQ_READ: pixel = get_px(px, py);
                default: ;
            endcase
            exp_pixel.push_back(pixel);
            exp_col.push_back(cur_x[6:0]);
            exp_row.push_back(cur_y[5:0]);
        endfunction

        function void check_result(logic [31:0] pixel, logic [6:0] col, logic [5:0] row);
            logic [31:0] e_pix;
            logic [6:0] e_col;
            logic [5:0] e_row;
            if (exp_pixel.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected response pixel=%h col=%0d row=%0d",
                                           pixel, col, row);
                return;
            end
            e_pix = exp_pixel.pop_front();
            e_col = exp_col.pop_front();
            e_row = exp_row.pop_front();
            if (pixel !== e_pix || col !== e_col || row !== e_row) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected pixel=%h col=%0d row=%0d, got %h %0d %0d",
                             e_pix, e_col, e_row, pixel, col, row);
            end
        endfunction

        function int pending();
            return exp_pixel.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid, s_ready;
    logic [2:0]  s_req_type;
    logic [7:0]  s_char_code;
    logic [6:0]  s_pos_x;
    logic [5:0]  s_pos_y;
    logic [3:0]  s_glyph_row_index;
    logic [7:0]  s_glyph_row_bits;
    logic        m_valid, m_ready;
    logic [31:0] m_pixel_value;
    logic [6:0]  m_cursor_col;
    logic [5:0]  m_cursor_row;
    logic        cfg_valid, cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    console_scoreboard sb = new();
    bit glyph_written [tcgr_pkg::GLYPH_DEPTH];
    int send_idle;
    int recv_stall;
    int cycles;
    logic [7:0] font_codes [6];

    text_console_glyph_renderer DUT (.*);

    initial aclk = 0;
    always #1 aclk = ~aclk;

    // Response side: random stalls, check each accepted response
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_pixel_value, m_cursor_col, m_cursor_row);
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_req(logic [2:0] req, logic [7:0] code, logic [6:0] px,
                            logic [5:0] py, logic [3:0] gi, logic [7:0] gb);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid           <= 1'b1;
        s_req_type        <= req;
        s_char_code       <= code;
        s_pos_x           <= px;
        s_pos_y           <= py;
        s_glyph_row_index <= gi;
        s_glyph_row_bits  <= gb;
        do @(posedge aclk); while (!s_ready);
        if (req == tcgr_pkg::REQ_LOAD && gi < sb.rows_eff() &&
            code * sb.rows_eff() + gi < tcgr_pkg::GLYPH_DEPTH)
            glyph_written[code * sb.rows_eff() + gi] = 1'b1;
        sb.note_request(req, code, px, py, gi, gb);
    endtask

    // Wait until every response is back and the engine is idle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_regs(logic [31:0] fg, logic [31:0] bg, int rows, bit en,
                              int width, int height);
        logic [31:0] vals [6];
        vals = '{fg, bg, 32'(rows), 32'(en), 32'(width), 32'(height)};
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(i[2:0], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic bit glyph_ready(logic [7:0] code);
        int r, addr;
        r = sb.rows_eff();
        for (int dy = 0; dy < r; dy++) begin
            addr = code * r + dy;
            if (addr < tcgr_pkg::GLYPH_DEPTH && !glyph_written[addr]) return 0;
        end
        return 1;
    endfunction

    // Load full glyphs for a few codes so that text can be drawn
    task automatic load_font();
        for (int i = 0; i < 6; i++) begin
            font_codes[i] = 8'($urandom_range(255));
            for (int gi = 0; gi < sb.rows_eff(); gi++)
                send_req(tcgr_pkg::REQ_LOAD, font_codes[i], 7'($urandom), 6'($urandom),
                         gi[3:0], 8'($urandom));
        end
    endtask

    task automatic rand_request();
        int sel;
        logic [7:0] code;
        logic [6:0] px;
        logic [5:0] py;
        sel = $urandom_range(99);
        px = 7'($urandom);
        py = 6'($urandom);
        if ($urandom_range(1)) begin
            px = 7'($urandom_range(sb.vis_w() - 1));
            py = 6'($urandom_range(sb.vis_h() - 1));
        end
        if (sel < 40) begin
            if ($urandom_range(9) == 0) code = tcgr_pkg::NEWLINE_CODE;
            else begin
                code = 8'($urandom);
                if (!glyph_ready(code)) code = font_codes[$urandom_range(5)];
            end
            send_req(tcgr_pkg::REQ_CHAR, code, px, py, 4'($urandom), 8'($urandom));
        end else if (sel < 50)
            send_req(tcgr_pkg::REQ_BS, 8'($urandom), px, py, 4'($urandom), 8'($urandom));
        else if (sel < 58)
            send_req(tcgr_pkg::REQ_MOVE, 8'($urandom), px, py, 4'($urandom), 8'($urandom));
        else if (sel < 59)
            send_req(tcgr_pkg::REQ_CLEAR, 8'($urandom), px, py, 4'($urandom), 8'($urandom));
        else if (sel < 75)
            send_req(tcgr_pkg::REQ_LOAD, 8'($urandom), px, py, 4'($urandom), 8'($urandom));
        else if (sel < 97)
            send_req(tcgr_pkg::REQ_READ, 8'($urandom), px, py, 4'($urandom), 8'($urandom));
        else send_req($urandom_range(1) ? REQ_SPARE_A : REQ_SPARE_B,
                      8'($urandom), px, py, 4'($urandom), 8'($urandom));
    endtask

    initial begin
        logic [7:0] pattern [4];
        pattern = '{8'hFF, 8'h80, 8'h01, 8'h00};
        aresetn = 0; s_valid = 0; m_ready = 0; cfg_valid = 0;
        s_req_type = '0; s_char_code = '0; s_pos_x = '0; s_pos_y = '0;
        s_glyph_row_index = '0; s_glyph_row_bits = '0;
        cfg_index = '0; cfg_data = '0;
        send_idle = 0; recv_stall = 0; cycles = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: glyph load, drawing at corners, wrap, scroll, home cases
        for (int gi = 0; gi < 16; gi++)
            send_req(tcgr_pkg::REQ_LOAD, 8'd65, '0, '0, gi[3:0], pattern[gi % 4]);
        send_req(tcgr_pkg::REQ_BS, '0, '0, '0, '0, '0);
        send_req(tcgr_pkg::REQ_CHAR, 8'd65, '0, '0, '0, '0);
        send_req(tcgr_pkg::REQ_READ, '0, 7'd0, 6'd0, '0, '0);
        send_req(tcgr_pkg::REQ_READ, '0, 7'd7, 6'd1, '0, '0);
        send_req(tcgr_pkg::REQ_CHAR, tcgr_pkg::NEWLINE_CODE, '0, '0, '0, '0);
        send_req(tcgr_pkg::REQ_MOVE, '0, 7'd127, 6'd63, '0, '0);
        send_req(tcgr_pkg::REQ_CHAR, 8'd65, '0, '0, '0, '0);
        send_req(tcgr_pkg::REQ_READ, '0, 7'd127, 6'd63, '0, '0);
        send_req(tcgr_pkg::REQ_BS, '0, '0, '0, '0, '0);
        send_req(REQ_SPARE_A, 8'hFF, 7'd127, 6'd63, 4'hF, 8'hFF);
        send_req(REQ_SPARE_B, '0, '0, '0, '0, '0);
        send_req(tcgr_pkg::REQ_CLEAR, '0, '0, '0, '0, '0);
        send_req(tcgr_pkg::REQ_READ, '0, 7'd0, 6'd0, '0, '0);

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: write_regs($urandom, $urandom, 16, 1, 128, 64);
                1: write_regs(32'hFFFF_FFFF, 32'h0, 1, 1, 8, 16);
                2: write_regs($urandom, $urandom, 16, 1, 128, 16);
                3: write_regs($urandom, $urandom, 8, 0, 32, 64);
                5: write_regs(32'h0, 32'hFFFF_FFFF, 5, 1, 40, 20);
                7: write_regs($urandom, $urandom, 16, 1, 16, 32);
                default: write_regs($urandom, $urandom, $urandom_range(1, 16), 1,
                                    $urandom_range(8, 128), $urandom_range(16, 64));
            endcase
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 86; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 86; end
                default: begin send_idle = 11; recv_stall = 11; end
            endcase
            // fonts stay loaded while drawing is off so later phases can use them
            if (ph == 3) begin
                sb.en = sb.en;
            end
            load_font();
            for (int n = 0; n < PHASE_REQS; n++) begin
                if (ph == 2 && n == PHASE_REQS / 2) drain();
                rand_request();
            end
        end

        drain();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### files.f
hdl/tcgr_pkg.sv
hdl/tcgr_ram.sv
hdl/tcgr_front.sv
hdl/tcgr_engine.sv
hdl/text_console_glyph_renderer.sv
dv/testbench.sv
